FILE: hdl/utf8d_pkg.sv
// Shared types, status codes and a helper function for the extended UTF-8 decoder.
// No dependencies.
package utf8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 31;
    localparam int unsigned LenW   = 3;
    localparam int unsigned CountW = 4;

    localparam logic [LenW-1:0] MaxSeqLen = LenW'(6);

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_INVALID   = 2'd1;
    localparam status_t STATUS_TRUNCATED = 2'd2;

    // One input item: a raw stream byte and the end-of-stream mark.
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } utf8d_in_t;

    // One result item.
    typedef struct packed {
        logic [ValueW-1:0] code_point;
        logic [LenW-1:0]   seq_length;
        status_t           status;
    } utf8d_out_t;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [LenW-1:0]   bytes_remaining;
        logic [ValueW-1:0] value_accumulator;
        logic [LenW-1:0]   announced_length;
    } utf8d_state_t;

    // Count leading one bits of a byte (0..8).
    function automatic logic [CountW-1:0] lead_ones(input logic [ByteW-1:0] b);
        logic [CountW-1:0] n;
        priority casez (b)
            8'b0???????: n = CountW'(0);
            8'b10??????: n = CountW'(1);
            8'b110?????: n = CountW'(2);
            8'b1110????: n = CountW'(3);
            8'b11110???: n = CountW'(4);
            8'b111110??: n = CountW'(5);
            8'b1111110?: n = CountW'(6);
            8'b11111110: n = CountW'(7);
            default:     n = CountW'(8);
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/utf8d_step.sv
// One decode step: next decoder state and optional result for one byte.
// Depends on utf8d_pkg.
module utf8d_step (
    input  utf8d_pkg::utf8d_state_t state,
    input  utf8d_pkg::utf8d_in_t    item,
    output utf8d_pkg::utf8d_state_t state_next,
    output logic                    emit,
    output utf8d_pkg::utf8d_out_t   result
);
    import utf8d_pkg::*;

    logic [CountW-1:0] n;
    logic [ByteW-1:0]  head_bits;
    logic [ValueW-1:0] acc_cont;
    logic [LenW-1:0]   rem_cont;
    logic [LenW-1:0]   n_len;

    assign n         = lead_ones(item.data_byte);
    assign n_len     = n[LenW-1:0];
    assign head_bits = item.data_byte & (8'hFF >> n);
    assign acc_cont  = {state.value_accumulator[ValueW-7:0], item.data_byte[5:0]};
    assign rem_cont  = state.bytes_remaining - LenW'(1);

    always_comb
    begin
        state_next        = state;
        emit              = 1'b0;
        result.code_point = {{(ValueW-ByteW){1'b0}}, item.data_byte};
        result.seq_length = LenW'(1);
        result.status     = STATUS_OK;

        if (state.bytes_remaining == '0)
        begin
            if (n == '0)
            begin
                emit = 1'b1;
            end
            else if (n == CountW'(1) || n > CountW'(MaxSeqLen))
            begin
                emit          = 1'b1;
                result.status = STATUS_INVALID;
            end
            else
            begin
                // Open a sequence; flush at once if the stream ends here.
                if (item.last_byte)
                begin
                    emit              = 1'b1;
                    result.code_point = {{(ValueW-ByteW){1'b0}}, head_bits};
                    result.seq_length = n_len;
                    result.status     = STATUS_TRUNCATED;
                end
                else
                begin
                    state_next.value_accumulator = {{(ValueW-ByteW){1'b0}}, head_bits};
                    state_next.announced_length  = n_len;
                    state_next.bytes_remaining   = n_len - LenW'(1);
                end
            end
        end
        else
        begin
            // Continuation: take low six bits, no check of the top bits.
            result.code_point = acc_cont;
            result.seq_length = state.announced_length;
            if (rem_cont == '0 || item.last_byte)
            begin
                emit          = 1'b1;
                result.status = (rem_cont == '0) ? STATUS_OK : STATUS_TRUNCATED;
                state_next    = '0;
            end
            else
            begin
                state_next.value_accumulator = acc_cont;
                state_next.bytes_remaining   = rem_cont;
            end
        end
    end

endmodule

FILE: hdl/utf8_extended_decoder.sv
// Extended UTF-8 decoder (1 to 6 byte sequences, 31-bit code points).
// A result is formed from the byte in the input register by the
// combinational decode step and held in the result register. Throughput:
// one byte per cycle while the result slot is free or being drained.
// Reset: rst_n clears the open sequence, the input and output valid flags.
// Depends on utf8d_pkg and utf8d_step.
module utf8_extended_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  utf8d_pkg::utf8d_in_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8d_pkg::utf8d_out_t out_item
);
    import utf8d_pkg::*;

    // Input register: holds one accepted byte until the decode step takes it.
    logic       in_valid_reg;
    logic       in_valid_next;
    utf8d_in_t  in_item_reg;

    // Decoder state: open sequence, accumulated bits, announced length.
    utf8d_state_t state_reg;
    utf8d_state_t state_next;
    utf8d_state_t step_state;

    // Result register.
    logic       out_valid_reg;
    logic       out_valid_next;
    utf8d_out_t out_item_reg;

    logic       step_emit;
    utf8d_out_t step_result;
    logic       advance;

    utf8d_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (step_state),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Advance the held byte whenever the result slot is free or being drained.
    // A byte that yields no result still waits for the slot.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        state_next    = advance ? step_state : state_reg;
        if (advance)
        begin
            out_valid_next = step_emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
        if (advance && step_emit)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: verif/utf8_extended_decoder_test.sv
// Self-checking testbench for utf8_extended_decoder: a byte-stream decode model predicts every
// result item, checked field by field under random idle, stall and hold-off on both channels.
// Depends on utf8d_pkg and the decoder RTL.
module utf8_extended_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving before the run is cut
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off in the pressure test
    localparam int PHASE_ITEMS  = 175;   // input items per random phase

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    utf8d_in_t  in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    utf8d_out_t out_item;

    // Decode state of the model, mirrored from the block's behavior.
    logic [2:0]  open_left = '0;      // continuation bytes still owed
    logic [30:0] partial_value = '0;  // bits gathered for the open sequence
    logic [2:0]  head_len = '0;       // length announced by the open head

    utf8d_out_t points_due[$];        // decoded code points waiting to come out
    int         mismatches = 0;
    int         sender_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    utf8_extended_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Decode one accepted byte against the model state and queue the code point it
    // completes, if any. A byte taken while a sequence is open is always a continuation,
    // whatever its top bits say.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int         ones;
        logic       emit;
        utf8d_out_t res;
        emit = 1'b0;
        res  = '0;
        if (open_left == 3'd0)
        begin
            ones = 0;
            while (ones < 8 && b[7 - ones])
                ones++;
            if (ones == 0)
            begin
                // Plain ASCII: out at once.
                res  = '{code_point: 31'(b), seq_length: 3'd1, status: STATUS_OK};
                emit = 1'b1;
            end
            else if (ones == 1 || ones > 6)
            begin
                // Stray continuation, FE or FF: flag it and pass the raw byte.
                res  = '{code_point: 31'(b), seq_length: 3'd1, status: STATUS_INVALID};
                emit = 1'b1;
            end
            else
            begin
                partial_value = 31'(b & (8'hFF >> ones));
                head_len      = 3'(ones);
                open_left     = 3'(ones - 1);
                if (last)
                begin
                    // Stream ends right after the head: flush what little there is.
                    res = '{code_point: partial_value, seq_length: head_len,
                            status: STATUS_TRUNCATED};
                    emit = 1'b1;
                    open_left = '0;
                    partial_value = '0;
                    head_len = '0;
                end
            end
        end
        else
        begin
            partial_value = {partial_value[24:0], b[5:0]};
            open_left     = open_left - 3'd1;
            if (open_left == 3'd0 || last)
            begin
                // Completion wins over the end mark; otherwise the stream cut it short.
                res = '{code_point: partial_value, seq_length: head_len,
                        status: (open_left == 3'd0) ? STATUS_OK : STATUS_TRUNCATED};
                emit = 1'b1;
                open_left = '0;
                partial_value = '0;
                head_len = '0;
            end
        end
        if (emit)
            points_due.push_back(res);
    endfunction

    // Random head byte announcing len bytes (len 1 gives an ASCII byte).
    function automatic logic [7:0] head_byte(input int len);
        logic [7:0] raw;
        logic [7:0] keep;
        logic [7:0] lead;
        raw = 8'($urandom);
        if (len == 1)
            return {1'b0, raw[6:0]};
        keep = 8'hFF >> (len + 1);
        lead = ~(8'hFF >> len);
        return (raw & keep) | lead;
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Offer one item, called and returning at a falling edge. Insert random idle cycles
    // first, then hold the payload until the block takes it and predict its result.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_byte(b, last);
        @(negedge clk);
    endtask

    // Drop valid and wait for every queued code point to come out; the watchdog bounds it.
    task automatic drain();
        in_valid <= 1'b0;
        while (points_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver side: drop ready at random, or for a whole hold-off stretch when asked.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result item with the oldest expected code point.
    always @(posedge clk)
    begin
        utf8d_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (points_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_item);
                mismatches++;
            end
            else
            begin
                want = points_due.pop_front();
                if (out_item.code_point !== want.code_point)
                begin
                    $display("%0t: code_point expected %h got %h",
                             $time, want.code_point, out_item.code_point);
                    mismatches++;
                end
                if (out_item.seq_length !== want.seq_length)
                begin
                    $display("%0t: seq_length expected %0d got %0d",
                             $time, want.seq_length, out_item.seq_length);
                    mismatches++;
                end
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_item.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cut the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("utf8_extended_decoder_test: errors");
                $finish;
            end
        end
    end

    // ASCII extremes, stray continuation, FE, and FF carrying the end mark.
    task automatic test_single_and_invalid();
        sender_idle_pct = 0;
        stall_pct = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    // Sequences of every length, 2 to 6, from the all-zero payload up to the full 31 bits.
    task automatic test_full_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // A head-looking byte in continuation position only feeds its low six bits.
        send_byte(8'hDF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hEF, 1'b0);
        repeat (2) send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        repeat (2) send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h88, 1'b0);
        repeat (3) send_byte(8'h80, 1'b0);
        // Largest value; the end mark lands on the completing byte.
        send_byte(8'hFD, 1'b0);
        repeat (4) send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        drain();
    endtask

    // Stream ends inside a sequence, and right on a lone head.
    task automatic test_stream_cut();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
        drain();
    endtask

    // Mostly well-formed sequences with random payload, plus cut-short sequences,
    // raw noise and sequences whose continuation bytes are fully random.
    task automatic test_random_stream(input int send_idle, input int recv_stall, input int count);
        int sent;
        int kind;
        int len;
        int cut;
        sender_idle_pct = send_idle;
        stall_pct = recv_stall;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                len = $urandom_range(1, 6);
                send_byte(head_byte(len), (len == 1) && ($urandom_range(19) == 0));
                for (int i = 1; i < len; i++)
                    send_byte(cont_byte(), (i == len - 1) && ($urandom_range(19) == 0));
                sent += len;
            end
            else if (kind < 72)
            begin
                len = $urandom_range(2, 6);
                cut = $urandom_range(1, len - 1);
                send_byte(head_byte(len), cut == 1);
                for (int i = 1; i < cut; i++)
                    send_byte(cont_byte(), i == cut - 1);
                sent += cut;
            end
            else if (kind < 88)
            begin
                send_byte(8'($urandom), $urandom_range(15) == 0);
                sent++;
            end
            else
            begin
                len = $urandom_range(2, 6);
                send_byte(head_byte(len), 1'b0);
                for (int i = 1; i < len; i++)
                    send_byte(8'($urandom), $urandom_range(15) == 0);
                sent += len;
            end
        end
        drain();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering ASCII,
    // so the block fills up and has to stall its input.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (40)
            send_byte(head_byte(1), 1'b0);
        drain();
    endtask

    initial
    begin
        // Hold reset low, then release it on a falling edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_and_invalid();
        test_full_sequences();
        test_stream_cut();
        test_random_stream(0, 0, PHASE_ITEMS);
        test_random_stream(61, 0, PHASE_ITEMS);
        test_backpressure();
        test_random_stream(0, 61, PHASE_ITEMS);
        test_random_stream(21, 21, PHASE_ITEMS);

        // Let the block settle before judging.
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("utf8_extended_decoder_test: clean");
        else
            $display("utf8_extended_decoder_test: errors");
        $finish;
    end

endmodule

FILE: sim.f
hdl/utf8d_pkg.sv
hdl/utf8d_step.sv
hdl/utf8_extended_decoder.sv
verif/utf8_extended_decoder_test.sv
